// ----- hw/rtl/two_fragment_reassembly_checker_core_macros.svh -----
// Assertion helpers shared by the checker RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TWO_FRAGMENT_REASSEMBLY_CHECKER_CORE_MACROS_SVH
`define TWO_FRAGMENT_REASSEMBLY_CHECKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFRC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfrc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfrc: next-cycle check failed");

`endif

// ----- hw/rtl/tfrc_pkg.sv -----
package tfrc_pkg;

    localparam int SLOT_COUNT_DEF    = 16;
    localparam int FRAME_MAX_DEF     = 1514;
    localparam int ENCRYPTED_MAX_DEF = 3072;
    localparam int DATA_MAX_DEF      = 1480;
    localparam int SHIM_SIZE_DEF     = 17;

    localparam logic [31:0] SHIM_MAGIC     = 32'h4A4D4202;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd60;
    localparam logic [15:0] MIN_PLAIN_LEN  = 16'd64;
    localparam logic [15:0] MIN_TOTAL_LEN  = 16'd29;
    localparam logic [15:0] TRAILER_LEN    = 16'd15;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [7:0]  FRAG_COUNT_REQ = 8'd2;
    localparam logic [7:0]  FRAG_FIRST     = 8'd0;
    localparam logic [7:0]  FRAG_LAST      = 8'd1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_CAPACITY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        ST_PLAIN_OK    = 3'd0,
        ST_STORED      = 3'd1,
        ST_REASSEMBLED = 3'd2,
        ST_INVALID     = 3'd3,
        ST_BAD_FRAG    = 3'd4,
        ST_SLOT_BUSY   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_READ,
        FSM_DECIDE
    } fsm_t;

    typedef struct packed {
        logic [15:0] rx_len;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ether_type;
        logic [7:0]  tail_byte;
        logic [31:0] magic;
        logic [31:0] frag_id;
        logic [15:0] total_len;
        logic [15:0] frag_offset;
        logic [15:0] frag_bytes;
        logic [7:0]  frag_index;
        logic [7:0]  frag_count;
    } frame_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  core_id;
        logic [15:0] prefix_len;
        logic [15:0] result_len;
    } verdict_t;

    // One slot table entry; the active bit lives in the same word.
    typedef struct packed {
        logic        active;
        logic [31:0] id;
        logic [6:0]  core;
        logic [15:0] total;
        logic [15:0] received;
        logic [47:0] dst;
        logic [47:0] src;
        logic [15:0] etype;
    } entry_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- hw/rtl/two_fragment_reassembly_checker_core.sv -----
// Two-fragment reassembly checker.
// Inputs: one frame's parsed fields on frame, taken at a clock edge where start
// is high and busy is low. Outputs: one verdict per frame on verdict, valid for
// exactly one cycle while done is high; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// expected ethertype (0), receive capacity (1) or worker count (2); cfg_ready
// is always high and an index of 3 is ignored. Write only while idle.
// Sequence: after the accepting edge the block reads the slot entry in the READ
// state, then decides and writes the entry back in the DECIDE state; done is a
// register set from DECIDE. busy stays high through READ and DECIDE, so a new
// frame is taken only after the last one has been decided. The steps are set
// by the registered reciprocal multiply that maps frag_id onto a slot, the
// registered read of the slot memory and the read-modify-write of that entry.
// Reset: registers return to their reset values and the slot memory is swept
// to inactive, one entry per cycle, so busy stays high until the sweep has
// written the last entry. Configuration writes are taken during the sweep.
`include "two_fragment_reassembly_checker_core_macros.svh"

module two_fragment_reassembly_checker_core #(
    parameter int SLOT_COUNT    = tfrc_pkg::SLOT_COUNT_DEF,
    parameter int FRAME_MAX     = tfrc_pkg::FRAME_MAX_DEF,
    parameter int ENCRYPTED_MAX = tfrc_pkg::ENCRYPTED_MAX_DEF,
    parameter int DATA_MAX      = tfrc_pkg::DATA_MAX_DEF,
    parameter int SHIM_SIZE     = tfrc_pkg::SHIM_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tfrc_pkg::frame_t                  frame,
    output logic                              done,
    output tfrc_pkg::verdict_t                verdict,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tfrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);
    import tfrc_pkg::*;

    localparam int ADDR_W = idx_width(SLOT_COUNT);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOT_COUNT - 1);

    fsm_t state_reg;
    fsm_t state_next;

    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] wr_addr;

    logic [15:0] exp_type_reg;
    logic [15:0] rx_cap_reg;
    logic [6:0]  workers_reg;

    frame_t   frame_reg;
    entry_t   rd_data_reg;
    entry_t   wr_data;
    verdict_t verdict_reg;
    verdict_t verdict_next;
    logic     done_reg;

    entry_t mem [SLOT_COUNT];

    logic accept;
    logic in_clear;
    logic in_read;
    logic in_decide;
    logic mem_we;
    logic lens_zero;

    // Decision terms.
    logic [6:0]  core;
    logic [16:0] tot15;
    logic [16:0] span;
    logic [17:0] expect_len;
    logic        invalid;
    logic        shape_bad;
    logic        busy_hit;
    logic        open_bad;
    logic        store_bad;
    logic        join_bad;
    logic        dec_we;
    logic        new_active;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign lens_zero = (verdict.prefix_len == 16'd0) && (verdict.result_len == 16'd0);

    tfrc_slot_index #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_slot_index (
        .clk  (clk),
        .load (accept),
        .id   (frame.frag_id),
        .slot (slot)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_CLEAR:
            begin
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_READ;
                end
            end
            FSM_READ:   state_next = FSM_DECIDE;
            FSM_DECIDE: state_next = FSM_IDLE;
            default:    state_next = FSM_CLEAR;
        endcase
    end

    // State outputs.
    always_comb
    begin
        busy      = 1'b1;
        in_clear  = 1'b0;
        in_read   = 1'b0;
        in_decide = 1'b0;
        unique case (state_reg)
            FSM_CLEAR:  in_clear  = 1'b1;
            FSM_IDLE:   busy      = 1'b0;
            FSM_READ:   in_read   = 1'b1;
            FSM_DECIDE: in_decide = 1'b1;
            default:    in_clear  = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= in_decide;
            if (in_clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_type_reg <= 16'd0;
            rx_cap_reg   <= 16'hFFFF;
            workers_reg  <= 7'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_TYPE: exp_type_reg <= cfg_data;
                CFG_RX_CAPACITY:   rx_cap_reg   <= cfg_data;
                CFG_WORKER_COUNT:  workers_reg  <= cfg_data[6:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_reg <= frame;
        end
        if (in_read)
        begin
            addr_reg <= slot;
        end
        if (in_decide)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (in_read)
        begin
            rd_data_reg <= mem[slot];
        end
    end

    // Frame checks and slot decision for the frame held in frame_reg.
    always_comb
    begin
        core       = frame_reg.tail_byte[6:0];
        tot15      = {1'b0, frame_reg.total_len} + {1'b0, TRAILER_LEN};
        span       = {1'b0, frame_reg.frag_offset} + {1'b0, frame_reg.frag_bytes};
        expect_len = {2'b00, ETH_HDR_LEN} + {2'b00, frame_reg.frag_bytes}
                   + 18'(SHIM_SIZE);

        invalid = (frame_reg.rx_len < MIN_FRAME_LEN)
               || ({1'b0, frame_reg.rx_len} > 17'(FRAME_MAX))
               || (frame_reg.rx_len > rx_cap_reg)
               || (frame_reg.ether_type != exp_type_reg)
               || (core >= workers_reg);

        shape_bad = (frame_reg.frag_count != FRAG_COUNT_REQ)
                 || (frame_reg.frag_index > FRAG_LAST)
                 || (tot15 <= 17'(FRAME_MAX))
                 || (tot15 > 17'(ENCRYPTED_MAX))
                 || (tot15 > {1'b0, rx_cap_reg})
                 || (frame_reg.frag_bytes == 16'd0)
                 || ({1'b0, frame_reg.frag_bytes} > 17'(DATA_MAX))
                 || (span > {1'b0, frame_reg.total_len})
                 || (expect_len != {2'b00, frame_reg.rx_len});

        // An open slot held by another packet is left untouched.
        busy_hit = rd_data_reg.active
                && ((rd_data_reg.id != frame_reg.frag_id)
                 || (rd_data_reg.core != core)
                 || (rd_data_reg.dst != frame_reg.dst_mac)
                 || (rd_data_reg.src != frame_reg.src_mac)
                 || (rd_data_reg.etype != frame_reg.ether_type));

        open_bad  = (frame_reg.frag_index != FRAG_FIRST)
                 || (frame_reg.frag_offset != 16'd0);

        store_bad = (frame_reg.total_len < MIN_TOTAL_LEN)
                 || ({1'b0, frame_reg.frag_bytes}
                     > ({1'b0, frame_reg.total_len} - {1'b0, MIN_TOTAL_LEN}));

        join_bad  = (rd_data_reg.total != frame_reg.total_len)
                 || (frame_reg.frag_index != FRAG_LAST)
                 || (frame_reg.frag_offset != rd_data_reg.received)
                 || (span != {1'b0, frame_reg.total_len});

        dec_we                  = 1'b0;
        new_active              = 1'b0;
        verdict_next.status     = ST_INVALID;
        verdict_next.core_id    = core;
        verdict_next.prefix_len = 16'd0;
        verdict_next.result_len = 16'd0;

        if (invalid)
        begin
            verdict_next.status = ST_INVALID;
        end
        else if (!frame_reg.tail_byte[7])
        begin
            verdict_next.status = (frame_reg.rx_len >= MIN_PLAIN_LEN)
                                ? ST_PLAIN_OK : ST_BAD_FRAG;
        end
        else if ((frame_reg.magic != SHIM_MAGIC) || shape_bad)
        begin
            verdict_next.status = ST_BAD_FRAG;
        end
        else if (busy_hit)
        begin
            verdict_next.status = ST_SLOT_BUSY;
        end
        else if (!rd_data_reg.active)
        begin
            if (open_bad || store_bad)
            begin
                verdict_next.status = ST_BAD_FRAG;
            end
            else
            begin
                verdict_next.status = ST_STORED;
                dec_we              = 1'b1;
                new_active          = 1'b1;
            end
        end
        else
        begin
            // Either outcome closes the slot.
            dec_we = 1'b1;
            if (join_bad)
            begin
                verdict_next.status = ST_BAD_FRAG;
            end
            else
            begin
                verdict_next.status     = ST_REASSEMBLED;
                verdict_next.prefix_len = frame_reg.frag_offset;
                verdict_next.result_len = tot15[15:0];
            end
        end
    end

    always_comb
    begin
        wr_data.active   = new_active && !in_clear;
        wr_data.id       = frame_reg.frag_id;
        wr_data.core     = core;
        wr_data.total    = frame_reg.total_len;
        wr_data.received = frame_reg.frag_bytes;
        wr_data.dst      = frame_reg.dst_mac;
        wr_data.src      = frame_reg.src_mac;
        wr_data.etype    = frame_reg.ether_type;
        wr_addr          = in_clear ? clr_cnt_reg : addr_reg;
        mem_we           = in_clear || (in_decide && dec_we);
    end

    `TFRC_ASSERT_NEXT(a_decide_gives_beat, state_reg == FSM_DECIDE, done)
    `TFRC_ASSERT_SAME(a_beat_leaves_idle, done, state_reg == FSM_IDLE)
    `TFRC_ASSERT_SAME(a_lengths_only_on_join, done && (verdict.status != ST_REASSEMBLED), lens_zero)
    `TFRC_ASSERT_SAME(a_no_accept_in_sweep, state_reg == FSM_CLEAR, busy && !done)

endmodule

// ----- hw/rtl/tfrc_slot_index.sv -----
module tfrc_slot_index #(
    parameter int SLOT_COUNT = tfrc_pkg::SLOT_COUNT_DEF
) (
    input  logic                                         clk,
    input  logic                                         load,
    input  logic [31:0]                                  id,
    output logic [tfrc_pkg::idx_width(SLOT_COUNT)-1:0]   slot
);
    import tfrc_pkg::*;

    localparam int ADDR_W = idx_width(SLOT_COUNT);
    // Reciprocal with 32 + ceil(log2 N) fraction bits gives an exact quotient
    // for every 32-bit identifier, so no correction step is needed.
    localparam int SHIFT = 32 + $clog2(SLOT_COUNT);
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT);
    localparam logic [32:0] RECIP = RECIP_WIDE[32:0];
    localparam logic [31:0] NDIV  = 32'(SLOT_COUNT);

    logic [31:0] id_reg;
    logic [64:0] prod_reg;
    logic [64:0] quot_wide;
    logic [31:0] quot;
    logic [31:0] quot_n;
    logic [31:0] rem;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg   <= id;
            prod_reg <= {33'd0, id} * {32'd0, RECIP};
        end
    end

    always_comb
    begin
        quot_wide = prod_reg >> SHIFT;
        quot      = quot_wide[31:0];
        quot_n    = quot * NDIV;
        rem       = id_reg - quot_n;
        slot      = rem[ADDR_W-1:0];
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import tfrc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SLOTS = SLOT_COUNT_DEF;
    // Smallest jumbo total that clears the frame limit, largest one that two
    // fragments can carry, and the smallest fragment payload that makes a
    // frame of legal length.
    localparam int TOTAL_LO = FRAME_MAX_DEF - TRAILER_LEN + 1;
    localparam int TOTAL_HI = 2 * DATA_MAX_DEF;
    localparam int MIN_FRAG = MIN_FRAME_LEN - ETH_HDR_LEN - SHIM_SIZE_DEF;

    typedef enum logic [1:0] {
        BEAT_FRAME,
        BEAT_WRITE,
        BEAT_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t           kind;
        frame_t               f;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
    } step_t;

    typedef struct packed {
        logic [31:0] id;
        logic [6:0]  core;
        logic [47:0] dst;
        logic [47:0] src;
        logic [15:0] total;
        logic [15:0] b0;
    } packet_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    frame_t               frame     = '0;
    logic                 done;
    verdict_t             verdict;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    // Register copies as the block holds them.
    logic [15:0] want_type = 16'd0;
    logic [15:0] rx_room   = 16'hFFFF;
    logic [6:0]  workers   = 7'd4;

    // Slot table copy.
    bit          slot_open  [SLOTS];
    logic [31:0] slot_tag   [SLOTS];
    logic [6:0]  slot_core  [SLOTS];
    logic [15:0] slot_total [SLOTS];
    logic [15:0] slot_got   [SLOTS];
    logic [47:0] slot_dst   [SLOTS];
    logic [47:0] slot_src   [SLOTS];
    logic [15:0] slot_type  [SLOTS];

    // Register values as the stimulus plan sees them at the point of planning.
    int gen_type    = 0;
    int gen_cap     = 65535;
    int gen_workers = 4;

    step_t    plan_q[$];
    verdict_t verdicts_due[$];
    packet_t  open_pkts[$];

    int errors     = 0;
    int verdicts   = 0;
    int gap_left   = 0;
    int burst_left = 0;

    two_fragment_reassembly_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .frame     (frame),
        .done      (done),
        .verdict   (verdict),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            CFG_EXPECTED_TYPE: want_type = data;
            CFG_RX_CAPACITY:   rx_room = data;
            CFG_WORKER_COUNT:  workers = data[6:0];
            default:           ;
        endcase
    endfunction

    function automatic verdict_t judge_frame(frame_t f);
        verdict_t   v;
        int         flen;
        int         tot;
        int         off;
        int         nb;
        int         s;
        logic [6:0] core;
        bit         fresh;
        flen = int'(f.rx_len);
        tot  = int'(f.total_len);
        off  = int'(f.frag_offset);
        nb   = int'(f.frag_bytes);
        core = f.tail_byte[6:0];
        s    = f.frag_id % SLOTS;
        v.status     = ST_BAD_FRAG;
        v.core_id    = core;
        v.prefix_len = '0;
        v.result_len = '0;
        if (flen < MIN_FRAME_LEN || flen > FRAME_MAX_DEF || flen > rx_room
            || f.ether_type != want_type || core >= workers)
        begin
            v.status = ST_INVALID;
        end
        else if (!f.tail_byte[7])
        begin
            if (flen >= MIN_PLAIN_LEN)
                v.status = ST_PLAIN_OK;
            else
                v.status = ST_BAD_FRAG;
        end
        else if (f.magic != SHIM_MAGIC || f.frag_count != FRAG_COUNT_REQ
                 || f.frag_index > FRAG_LAST
                 || tot + TRAILER_LEN <= FRAME_MAX_DEF
                 || tot + TRAILER_LEN > ENCRYPTED_MAX_DEF
                 || tot + TRAILER_LEN > rx_room
                 || nb == 0 || nb > DATA_MAX_DEF || off + nb > tot
                 || flen != ETH_HDR_LEN + nb + SHIM_SIZE_DEF)
        begin
            v.status = ST_BAD_FRAG;
        end
        else if (slot_open[s] && (slot_tag[s] != f.frag_id || slot_core[s] != core
                 || slot_dst[s] != f.dst_mac || slot_src[s] != f.src_mac
                 || slot_type[s] != f.ether_type))
        begin
            v.status = ST_SLOT_BUSY;
        end
        else if (!slot_open[s] && (f.frag_index != FRAG_FIRST || off != 0))
        begin
            v.status = ST_BAD_FRAG;
        end
        else
        begin
            fresh = !slot_open[s];
            if (fresh)
            begin
                slot_tag[s]   = f.frag_id;
                slot_core[s]  = core;
                slot_total[s] = f.total_len;
                slot_got[s]   = '0;
                slot_dst[s]   = f.dst_mac;
                slot_src[s]   = f.src_mac;
                slot_type[s]  = f.ether_type;
            end
            if (slot_total[s] != f.total_len
                || f.frag_index != (fresh ? FRAG_FIRST : FRAG_LAST)
                || off != slot_got[s]
                || (f.frag_index == FRAG_FIRST
                    && (tot < MIN_TOTAL_LEN || nb > tot - MIN_TOTAL_LEN))
                || (f.frag_index == FRAG_LAST && off + nb != tot))
            begin
                slot_open[s] = 1'b0;
                slot_got[s]  = '0;
                v.status     = ST_BAD_FRAG;
            end
            else if (f.frag_index == FRAG_FIRST)
            begin
                slot_got[s]  = f.frag_bytes;
                slot_open[s] = 1'b1;
                v.status     = ST_STORED;
            end
            else
            begin
                slot_open[s] = 1'b0;
                slot_got[s]  = '0;
                v.status     = ST_REASSEMBLED;
                v.prefix_len = f.frag_offset;
                v.result_len = f.total_len + TRAILER_LEN;
            end
        end
        return v;
    endfunction

    function automatic void plan_frame(frame_t f);
        step_t st;
        st      = '0;
        st.kind = BEAT_FRAME;
        st.f    = f;
        plan_q.push_back(st);
    endfunction

    function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        step_t st;
        st      = '0;
        st.kind = BEAT_WRITE;
        st.idx  = idx;
        st.data = data;
        plan_q.push_back(st);
        case (idx)
            CFG_EXPECTED_TYPE: gen_type = int'(data);
            CFG_RX_CAPACITY:   gen_cap = int'(data);
            CFG_WORKER_COUNT:  gen_workers = int'(data[6:0]);
            default:           ;
        endcase
    endfunction

    function automatic void plan_drain();
        step_t st;
        st      = '0;
        st.kind = BEAT_DRAIN;
        plan_q.push_back(st);
    endfunction

    function automatic frame_t plain_beat(int len, logic [6:0] core);
        frame_t f;
        f.rx_len      = 16'(len);
        f.dst_mac     = 48'({$urandom, $urandom});
        f.src_mac     = 48'({$urandom, $urandom});
        f.ether_type  = 16'(gen_type);
        f.tail_byte   = {1'b0, core};
        f.magic       = $urandom;
        f.frag_id     = $urandom;
        f.total_len   = 16'($urandom);
        f.frag_offset = 16'($urandom);
        f.frag_bytes  = 16'($urandom);
        f.frag_index  = 8'($urandom);
        f.frag_count  = 8'($urandom);
        return f;
    endfunction

    function automatic packet_t mk_pkt(logic [31:0] id, logic [6:0] core, int total, int b0);
        packet_t p;
        p.id    = id;
        p.core  = core;
        p.dst   = 48'({$urandom, $urandom});
        p.src   = 48'({$urandom, $urandom});
        p.total = 16'(total);
        p.b0    = 16'(b0);
        return p;
    endfunction

    function automatic frame_t frag_beat(packet_t p, logic [7:0] index);
        frame_t f;
        f.dst_mac    = p.dst;
        f.src_mac    = p.src;
        f.ether_type = 16'(gen_type);
        f.tail_byte  = {1'b1, p.core};
        f.magic      = SHIM_MAGIC;
        f.frag_id    = p.id;
        f.total_len  = p.total;
        f.frag_index = index;
        f.frag_count = FRAG_COUNT_REQ;
        if (index == FRAG_FIRST)
        begin
            f.frag_offset = '0;
            f.frag_bytes  = p.b0;
        end
        else
        begin
            f.frag_offset = p.b0;
            f.frag_bytes  = p.total - p.b0;
        end
        f.rx_len = 16'(ETH_HDR_LEN + f.frag_bytes + SHIM_SIZE_DEF);
        return f;
    endfunction

    // A well-formed packet when rx capacity and worker count allow: both fragments
    // fit the frame limit and the payload split leaves each one a legal length.
    function automatic packet_t new_packet();
        packet_t    p;
        int         top;
        int         lo;
        int         hi;
        int         tot;
        logic [6:0] core;
        top = (gen_cap - TRAILER_LEN < TOTAL_HI) ? gen_cap - TRAILER_LEN : TOTAL_HI;
        if (top < TOTAL_LO)
            top = TOTAL_LO + 200;
        tot  = $urandom_range(TOTAL_LO, top);
        lo   = (tot - DATA_MAX_DEF > MIN_FRAG) ? tot - DATA_MAX_DEF : MIN_FRAG;
        hi   = (tot - MIN_TOTAL_LEN < DATA_MAX_DEF) ? tot - MIN_TOTAL_LEN : DATA_MAX_DEF;
        core = 7'((gen_workers > 0) ? $urandom_range(0, gen_workers - 1) : $urandom);
        p = mk_pkt($urandom, core, tot, $urandom_range(lo, hi));
        // Now and then land on the slot of a packet that may still be open.
        if (open_pkts.size() > 0 && $urandom_range(0, 3) == 0)
            p.id[3:0] = open_pkts[$].id[3:0];
        return p;
    endfunction

    function automatic frame_t mutate(frame_t f);
        int b;
        b = $urandom_range(0, 47);
        case ($urandom_range(0, 13))
            0:  f.frag_id[31:4] = ~f.frag_id[31:4];
            1:  f.tail_byte[6:0] = f.tail_byte[6:0] + 7'd1;
            2:  f.dst_mac[b] = ~f.dst_mac[b];
            3:  f.src_mac[b] = ~f.src_mac[b];
            4:  f.total_len = f.total_len + 16'd1;
            5:
            begin
                f.frag_offset = f.frag_offset + 16'd1;
                f.frag_bytes  = f.frag_bytes - 16'd1;
                f.rx_len      = f.rx_len - 16'd1;
            end
            6:
            begin
                f.frag_bytes = f.frag_bytes - 16'd1;
                f.rx_len     = f.rx_len - 16'd1;
            end
            7:  f.frag_index = 8'($urandom_range(2, 255));
            8:  f.frag_count = 8'(FRAG_COUNT_REQ + $urandom_range(1, 255));
            9:  f.magic[b % 32] = ~f.magic[b % 32];
            10: f.rx_len = f.rx_len + 16'd1;
            11: f.ether_type = f.ether_type ^ 16'h0100;
            12:
            begin
                f.frag_bytes = '0;
                f.rx_len     = 16'(ETH_HDR_LEN + SHIM_SIZE_DEF);
            end
            default: f.frag_index = f.frag_index ^ 8'd1;
        endcase
        return f;
    endfunction

    function automatic void plan_random(int n);
        packet_t    p;
        frame_t     f;
        int         k;
        int         pick;
        int         pause_at;
        int         len;
        logic [6:0] core;
        pause_at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                plan_drain();
            pick = $urandom_range(0, 99);
            if (open_pkts.size() == 0 && ((pick >= 30 && pick < 60) || (pick >= 90 && pick < 95)))
                pick = 0;
            if (pick < 30)
            begin
                p = new_packet();
                plan_frame(frag_beat(p, FRAG_FIRST));
                open_pkts.push_back(p);
                if (open_pkts.size() > 6)
                    void'(open_pkts.pop_front());
            end
            else if (pick < 60)
            begin
                k = $urandom_range(0, open_pkts.size() - 1);
                f = frag_beat(open_pkts[k], FRAG_LAST);
                if ($urandom_range(0, 6) == 0)
                    f = mutate(f);
                plan_frame(f);
                open_pkts.delete(k);
            end
            else if (pick < 65)
            begin
                plan_frame(mutate(frag_beat(new_packet(), FRAG_FIRST)));
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 5))
                    0:       len = $urandom_range(MIN_FRAME_LEN, MIN_PLAIN_LEN - 1);
                    1:       len = MIN_PLAIN_LEN;
                    2:       len = FRAME_MAX_DEF;
                    5:       len = $urandom_range(0, 65535);
                    default: len = $urandom_range(MIN_PLAIN_LEN, FRAME_MAX_DEF);
                endcase
                core = 7'($urandom);
                if (gen_workers > 0 && $urandom_range(0, 7) != 0)
                    core = 7'($urandom_range(0, gen_workers - 1));
                plan_frame(plain_beat(len, core));
            end
            else if (pick < 90)
            begin
                f = plain_beat($urandom_range(0, 65535), 7'($urandom));
                f.ether_type = 16'($urandom);
                f.tail_byte  = 8'($urandom);
                if ($urandom_range(0, 1) == 0)
                    f.ether_type = 16'(gen_type);
                plan_frame(f);
            end
            else if (pick < 95)
            begin
                // A repeated first fragment on a packet that may still be open.
                plan_frame(frag_beat(open_pkts[$urandom_range(0, open_pkts.size() - 1)],
                                     FRAG_FIRST));
            end
            else
            begin
                plan_frame(frag_beat(new_packet(), FRAG_LAST));
            end
        end
    endfunction

    task automatic report(string what);
        errors++;
        if (errors <= 200)
            $display("verdict %0d: %s", verdicts, what);
    endtask

    // Driver: frames go out in bursts; register writes and pauses wait until
    // the block has delivered every verdict it owes.
    always @(posedge clk)
    begin
        step_t head;
        bit    go_frame;
        bit    go_write;
        go_frame = 1'b0;
        go_write = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
                verdicts_due.push_back(judge_frame(frame));
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (!((start && busy) || (cfg_valid && !cfg_ready)))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (plan_q.size() > 0)
                begin
                    head = plan_q[0];
                    case (head.kind)
                        BEAT_FRAME:
                        begin
                            go_frame = 1'b1;
                            frame <= head.f;
                            void'(plan_q.pop_front());
                            if (burst_left > 0)
                            begin
                                burst_left--;
                            end
                            else
                            begin
                                burst_left = ($urandom_range(0, 4) == 0) ?
                                             $urandom_range(30, 120) : $urandom_range(1, 12);
                                gap_left   = $urandom_range(1, 7);
                            end
                        end
                        BEAT_WRITE:
                        begin
                            if (verdicts_due.size() == 0 && !done)
                            begin
                                go_write = 1'b1;
                                cfg_index <= head.idx;
                                cfg_data  <= head.data;
                                void'(plan_q.pop_front());
                            end
                        end
                        default:
                        begin
                            if (verdicts_due.size() == 0 && !done)
                                void'(plan_q.pop_front());
                        end
                    endcase
                end
                start     <= go_frame;
                cfg_valid <= go_write;
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && done)
        begin
            verdicts++;
            if (verdicts_due.size() == 0)
            begin
                report("verdict with no frame outstanding");
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict.status !== want.status)
                    report($sformatf("status %0d, expected %0d", verdict.status, want.status));
                if (verdict.core_id !== want.core_id)
                    report($sformatf("core_id %0d, expected %0d",
                                     verdict.core_id, want.core_id));
                if (verdict.prefix_len !== want.prefix_len)
                    report($sformatf("prefix_len %0d, expected %0d",
                                     verdict.prefix_len, want.prefix_len));
                if (verdict.result_len !== want.result_len)
                    report($sformatf("result_len %0d, expected %0d",
                                     verdict.result_len, want.result_len));
            end
        end
    end

    initial
    begin
        #400000;
        $display("two_fragment_reassembly_checker_core regression: fail");
        $finish;
    end

    initial
    begin
        packet_t pa;
        packet_t pb;
        packet_t pc;
        packet_t pd;
        packet_t pe;
        packet_t pg;
        packet_t ph;
        frame_t  f;

        pa = mk_pkt(32'h1000_0005, 7'd0, 1600, 800);
        pa.dst = '1;
        pa.src = '0;
        pc = mk_pkt(32'h2000_0005, 7'd1, 1600, 800);
        pb = mk_pkt(32'hABCD_0007, 7'd2, 2000, 1000);
        pd = mk_pkt(32'h0000_0008, 7'd3, TOTAL_LO - 1, 100);
        pe = mk_pkt(32'h0000_000A, 7'd1, TOTAL_LO, TOTAL_LO - MIN_TOTAL_LEN + 1);
        pg = mk_pkt(32'hFFFF_FFF3, 7'd3, TOTAL_HI, DATA_MAX_DEF);
        ph = mk_pkt(32'h0000_0009, 7'd2, 2500, 1200);

        // Plain frames around the length limits, bad worker and ethertype.
        plan_frame(plain_beat(MIN_PLAIN_LEN, 7'd0));
        plan_frame(plain_beat(MIN_PLAIN_LEN - 1, 7'd1));
        plan_frame(plain_beat(MIN_FRAME_LEN, 7'd2));
        plan_frame(plain_beat(MIN_FRAME_LEN - 1, 7'd0));
        plan_frame(plain_beat(FRAME_MAX_DEF, 7'd3));
        plan_frame(plain_beat(FRAME_MAX_DEF + 1, 7'd0));
        plan_frame(plain_beat(100, 7'd4));
        f = plain_beat(100, 7'd0);
        f.ether_type = 16'hFFFF;
        plan_frame(f);

        f = frag_beat(pa, FRAG_FIRST);
        f.magic[0] = ~f.magic[0];
        plan_frame(f);
        plan_frame(frag_beat(pb, FRAG_LAST));

        // Open, collide on the same slot with another id, then complete.
        plan_frame(frag_beat(pa, FRAG_FIRST));
        plan_frame(frag_beat(pc, FRAG_FIRST));
        plan_frame(frag_beat(pa, FRAG_LAST));

        // A short second fragment tears the slot down, so the retry fails.
        plan_frame(frag_beat(pb, FRAG_FIRST));
        f = frag_beat(pb, FRAG_LAST);
        f.frag_bytes = f.frag_bytes - 16'd1;
        f.rx_len     = f.rx_len - 16'd1;
        plan_frame(f);
        plan_frame(frag_beat(pb, FRAG_LAST));

        plan_frame(frag_beat(pd, FRAG_FIRST));
        pd.total = 16'(ENCRYPTED_MAX_DEF - TRAILER_LEN + 1);
        plan_frame(frag_beat(pd, FRAG_FIRST));
        plan_frame(frag_beat(pe, FRAG_FIRST));

        f = frag_beat(pg, FRAG_FIRST);
        f.frag_index = 8'd2;
        plan_frame(f);
        f = frag_beat(pg, FRAG_FIRST);
        f.frag_count = FRAG_COUNT_REQ + 8'd1;
        plan_frame(f);
        plan_frame(frag_beat(pg, FRAG_FIRST));
        plan_frame(frag_beat(pg, FRAG_LAST));

        // Left open across the ethertype change below.
        plan_frame(frag_beat(ph, FRAG_FIRST));

        plan_write(CFG_EXPECTED_TYPE, 16'h88B5);
        plan_write(CFG_RX_CAPACITY, 16'hFFFF);
        plan_write(CFG_WORKER_COUNT, {9'($urandom), 7'd127});
        plan_frame(frag_beat(ph, FRAG_LAST));
        plan_random(280);

        plan_write(CFG_EXPECTED_TYPE, 16'hFFFF);
        plan_write(CFG_RX_CAPACITY, 16'd3000);
        plan_write(CFG_WORKER_COUNT, {9'($urandom), 7'd1});
        plan_random(200);

        plan_write(CFG_EXPECTED_TYPE, 16'h0000);
        plan_write(CFG_RX_CAPACITY, 16'd1600);
        plan_write(CFG_WORKER_COUNT, {9'($urandom), 7'd64});
        plan_random(200);

        plan_write(CFG_RX_CAPACITY, 16'd0);
        plan_write(CFG_WORKER_COUNT, {9'($urandom), 7'd0});
        plan_write(CFG_EXPECTED_TYPE, 16'($urandom));
        plan_random(40);

        plan_write(CFG_SPARE, 16'($urandom));
        plan_write(CFG_EXPECTED_TYPE, 16'($urandom));
        plan_write(CFG_RX_CAPACITY, 16'hFFFF);
        plan_write(CFG_WORKER_COUNT, {9'($urandom), 7'($urandom_range(1, 127))});
        plan_random(400);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (plan_q.size() != 0 || start || cfg_valid || verdicts_due.size() != 0);
        repeat (10) @(negedge clk);

        if (errors == 0)
            $display("two_fragment_reassembly_checker_core regression: pass");
        else
            $display("two_fragment_reassembly_checker_core regression: fail");
        $finish;
    end

endmodule
